// File: rtl/core/explicit_fd_grid_step_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms of the concurrent checks used by the grid step modules.
// ---------------------------------------------------------------------------
`ifndef EXPLICIT_FD_GRID_STEP_ASSERT_SVH
`define EXPLICIT_FD_GRID_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define EFD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid step assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define EFD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid step assertion failed");

`endif

// File: rtl/core/efd_pkg.sv
// ---------------------------------------------------------------------------
// Grid step package
// Word types, configuration layout and queue entry shared by the modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package efd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_R     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLATILITY = 2'd2;

  localparam logic [30:0] STEP_DT_RESET    = 31'd655;
  localparam logic [31:0] RATE_R_RESET     = 32'd0;
  localparam logic [30:0] VOLATILITY_RESET = 31'd13107;

  typedef struct packed {
    logic signed [31:0] v_sample;
    logic signed [31:0] grid_x;
    logic signed [31:0] d1_lower;
    logic signed [31:0] d1_center;
    logic signed [31:0] d1_upper;
    logic signed [31:0] d2_lower;
    logic signed [31:0] d2_center;
    logic signed [31:0] d2_upper;
    logic signed [31:0] boundary_value;
    logic               first_node;
    logic               last_node;
  } node_word_t;

  typedef struct packed {
    logic signed [31:0] u_value;
    logic               pass_end;
  } result_word_t;

  typedef struct packed {
    logic        [30:0] step_dt;
    logic signed [31:0] rate_r;
    logic        [30:0] volatility;
  } cfg_t;

  typedef struct packed {
    logic lead;
    logic interior;
    logic tail;
  } job_ctl_t;

  typedef struct packed {
    job_ctl_t           ctl;
    logic signed [31:0] bnd;
    logic signed [31:0] v_lower;
    logic signed [31:0] v_middle;
    logic signed [31:0] v_upper;
    logic signed [31:0] x_middle;
    logic signed [31:0] c1_lower;
    logic signed [31:0] c1_center;
    logic signed [31:0] c1_upper;
    logic signed [31:0] c2_lower;
    logic signed [31:0] c2_center;
    logic signed [31:0] c2_upper;
  } job_t;

endpackage

// File: rtl/core/efd_fifo.sv
// ---------------------------------------------------------------------------
// Job queue
// Small register queue that decouples the node front end from the solver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module efd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/efd_mul.sv
// ---------------------------------------------------------------------------
// Fixed-point multiplier
// Signed product in 16-bit multiplier slices, one slice a cycle, truncated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "explicit_fd_grid_step_assert.svh"

module efd_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic                         busy,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] p
);

  localparam int CH  = 16;
  localparam int NCH = (DATA_WIDTH + CH - 1) / CH;
  localparam int BW  = NCH * CH;
  localparam int AW  = BW + DATA_WIDTH + FRAC_BITS;
  localparam int CW  = $clog2(NCH + 1);

  logic signed [DATA_WIDTH-1:0]  a_q;
  logic        [BW-1:0]          b_q;
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          acc_next;
  logic        [CW-1:0]          cnt;
  logic        [CH-1:0]          chunk;
  logic signed [CH:0]            chunk_ext;
  logic signed [DATA_WIDTH+CH:0] partial;

  always_comb begin
    chunk     = b_q[BW-1 -: CH];
    chunk_ext = (cnt == CW'(NCH)) ? {chunk[CH-1], chunk} : {1'b0, chunk};
    partial   = a_q * chunk_ext;
    acc_next  = (acc <<< CH) + AW'(partial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NCH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= BW'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
      b_q <= b_q << CH;
      if (cnt == CW'(1)) begin
        p <= acc_next[FRAC_BITS +: DATA_WIDTH];
      end
    end
  end

  `EFD_ASSERT_NEXT(a_last_slice_done, busy && !start && (cnt == CW'(1)), done)
  `EFD_ASSERT_IMPL(a_busy_count, busy, cnt != '0)

endmodule

// File: rtl/core/efd_front.sv
// ---------------------------------------------------------------------------
// Node front end
// Holds the two-node window; a node with results becomes a queued job word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module efd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                node_valid,
  output logic                node_ready,
  input  efd_pkg::node_word_t node,
  output logic                job_valid,
  input  logic                job_ready,
  output efd_pkg::job_t       job
);

  import efd_pkg::*;

  logic signed [31:0] v_lower;
  logic signed [31:0] v_middle;
  logic signed [31:0] x_middle;
  logic signed [31:0] c1_lower_m;
  logic signed [31:0] c1_center_m;
  logic signed [31:0] c2_lower_m;
  logic signed [31:0] c2_center_m;
  logic [1:0]         nodes_seen;
  logic [1:0]         seen_eff;
  logic [1:0]         nodes_seen_next;
  logic               accept;

  assign node_ready = job_ready;
  assign accept     = node_valid && job_ready;

  always_comb begin
    seen_eff = node.first_node ? 2'd0 : nodes_seen;
    if (node.last_node) begin
      nodes_seen_next = 2'd0;
    end else if (seen_eff == 2'd2) begin
      nodes_seen_next = 2'd2;
    end else begin
      nodes_seen_next = seen_eff + 2'd1;
    end

    job.ctl.lead     = node.first_node;
    job.ctl.interior = (seen_eff == 2'd2);
    job.ctl.tail     = node.last_node;
    job.bnd          = node.boundary_value;
    job.v_lower      = v_lower;
    job.v_middle     = v_middle;
    job.v_upper      = node.v_sample;
    job.x_middle     = x_middle;
    job.c1_lower     = c1_lower_m;
    job.c1_center    = c1_center_m;
    job.c1_upper     = node.d1_upper;
    job.c2_lower     = c2_lower_m;
    job.c2_center    = c2_center_m;
    job.c2_upper     = node.d2_upper;

    job_valid = node_valid && (job.ctl.lead || job.ctl.interior || job.ctl.tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_seen  <= 2'd0;
      v_lower     <= '0;
      v_middle    <= '0;
      x_middle    <= '0;
      c1_lower_m  <= '0;
      c1_center_m <= '0;
      c2_lower_m  <= '0;
      c2_center_m <= '0;
    end else if (accept) begin
      nodes_seen  <= nodes_seen_next;
      v_lower     <= v_middle;
      v_middle    <= node.v_sample;
      x_middle    <= node.grid_x;
      c1_lower_m  <= node.d1_lower;
      c1_center_m <= node.d1_center;
      c2_lower_m  <= node.d2_lower;
      c2_center_m <= node.d2_center;
    end
  end

endmodule

// File: rtl/core/efd_back.sv
// ---------------------------------------------------------------------------
// Solver back end
// Runs interior jobs on the shared multiplier and drives the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "explicit_fd_grid_step_assert.svh"

module efd_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  efd_pkg::cfg_t         cfg,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  efd_pkg::job_t         pop_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output efd_pkg::result_word_t result
);

  import efd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LEAD = 5'b00010,
    S_CALC = 5'b00100,
    S_INT  = 5'b01000,
    S_TAIL = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    OP_D1L, OP_D1C, OP_D1U, OP_D2L, OP_D2C, OP_D2U, OP_T0, OP_RX,
    OP_T1, OP_SS, OP_HSS, OP_XX, OP_PROD, OP_T2, OP_FIN
  } op_t;

  localparam logic [DATA_WIDTH-1:0] HALF =
    {{(DATA_WIDTH - 1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  state_t state;
  state_t state_next;
  op_t    op;
  logic   pending;
  job_t   job;

  logic signed [DATA_WIDTH-1:0] d1;
  logic signed [DATA_WIDTH-1:0] d2;
  logic signed [DATA_WIDTH-1:0] sum;
  logic signed [DATA_WIDTH-1:0] tmp;
  logic signed [DATA_WIDTH-1:0] tmp2;
  logic signed [DATA_WIDTH-1:0] u;

  logic signed [DATA_WIDTH-1:0] vl, vm, vu, xm;
  logic signed [DATA_WIDTH-1:0] c1l, c1c, c1u, c2l, c2c, c2u;
  logic signed [DATA_WIDTH-1:0] dt, r, s;

  logic                         mul_start;
  logic                         mul_busy;
  logic                         mul_done;
  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [DATA_WIDTH-1:0] mul_b;
  logic signed [DATA_WIDTH-1:0] mul_p;

  logic         out_free;
  logic         out_load;
  result_word_t out_word;

  assign vl  = DATA_WIDTH'(job.v_lower);
  assign vm  = DATA_WIDTH'(job.v_middle);
  assign vu  = DATA_WIDTH'(job.v_upper);
  assign xm  = DATA_WIDTH'(job.x_middle);
  assign c1l = DATA_WIDTH'(job.c1_lower);
  assign c1c = DATA_WIDTH'(job.c1_center);
  assign c1u = DATA_WIDTH'(job.c1_upper);
  assign c2l = DATA_WIDTH'(job.c2_lower);
  assign c2c = DATA_WIDTH'(job.c2_center);
  assign c2u = DATA_WIDTH'(job.c2_upper);
  assign dt  = DATA_WIDTH'(cfg.step_dt);
  assign r   = DATA_WIDTH'(cfg.rate_r);
  assign s   = DATA_WIDTH'(cfg.volatility);

  assign out_free = !result_valid || result_ready;

  always_comb begin
    case (op)
      OP_D1L:  begin mul_a = c1l;  mul_b = vl;   end
      OP_D1C:  begin mul_a = c1c;  mul_b = vm;   end
      OP_D1U:  begin mul_a = c1u;  mul_b = vu;   end
      OP_D2L:  begin mul_a = c2l;  mul_b = vl;   end
      OP_D2C:  begin mul_a = c2c;  mul_b = vm;   end
      OP_D2U:  begin mul_a = c2u;  mul_b = vu;   end
      OP_T0:   begin mul_a = r;    mul_b = vm;   end
      OP_RX:   begin mul_a = r;    mul_b = xm;   end
      OP_T1:   begin mul_a = tmp;  mul_b = d1;   end
      OP_SS:   begin mul_a = s;    mul_b = s;    end
      OP_HSS:  begin mul_a = HALF; mul_b = tmp;  end
      OP_XX:   begin mul_a = xm;   mul_b = xm;   end
      OP_PROD: begin mul_a = tmp;  mul_b = tmp2; end
      OP_T2:   begin mul_a = tmp;  mul_b = d2;   end
      OP_FIN:  begin mul_a = dt;   mul_b = sum;  end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_word   = '0;
    pop_ready  = 1'b0;
    mul_start  = 1'b0;
    case (state)
      S_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_data.ctl.lead) begin
            state_next = S_LEAD;
          end else if (pop_data.ctl.interior) begin
            state_next = S_CALC;
          end else if (pop_data.ctl.tail) begin
            state_next = S_TAIL;
          end
        end
      end
      S_LEAD: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_word.u_value  = job.bnd;
          out_word.pass_end = 1'b0;
          if (job.ctl.interior) begin
            state_next = S_CALC;
          end else if (job.ctl.tail) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CALC: begin
        mul_start = pending;
        if (mul_done && (op == OP_FIN)) begin
          state_next = S_INT;
        end
      end
      S_INT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_word.u_value  = 32'(u);
          out_word.pass_end = 1'b0;
          state_next        = job.ctl.tail ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_word.u_value  = job.bnd;
          out_word.pass_end = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      op           <= OP_D1L;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state_next == S_CALC) && (state != S_CALC)) begin
        op      <= OP_D1L;
        pending <= 1'b1;
      end else if (state == S_CALC) begin
        if (mul_start) begin
          pending <= 1'b0;
        end
        if (mul_done && (op != OP_FIN)) begin
          op      <= op_t'(4'(op + 4'd1));
          pending <= 1'b1;
        end
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job <= pop_data;
    end
    if (out_load) begin
      result <= out_word;
    end
    if (mul_done) begin
      case (op)
        OP_D1L:  d1   <= mul_p;
        OP_D1C:  d1   <= d1 + mul_p;
        OP_D1U:  d1   <= d1 + mul_p;
        OP_D2L:  d2   <= mul_p;
        OP_D2C:  d2   <= d2 + mul_p;
        OP_D2U:  d2   <= d2 + mul_p;
        OP_T0:   sum  <= mul_p;
        OP_RX:   tmp  <= mul_p;
        OP_T1:   sum  <= sum - mul_p;
        OP_SS:   tmp  <= mul_p;
        OP_HSS:  tmp  <= mul_p;
        OP_XX:   tmp2 <= mul_p;
        OP_PROD: tmp  <= mul_p;
        OP_T2:   sum  <= sum - mul_p;
        OP_FIN:  u    <= vm - mul_p;
        default: u    <= u;
      endcase
    end
  end

  efd_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .done (mul_done),
    .p    (mul_p)
  );

  `EFD_ASSERT_IMPL(a_start_when_free, mul_start, !mul_busy)
  `EFD_ASSERT_IMPL(a_done_in_calc, mul_done, state == S_CALC)
  `EFD_ASSERT_IMPL(a_int_from_job, state == S_INT, job.ctl.interior)

endmodule

// File: rtl/core/explicit_fd_grid_step.sv
// ---------------------------------------------------------------------------
// Explicit finite-difference grid step
// One explicit time step of the Black-Scholes equation over a node stream.
// ---------------------------------------------------------------------------
// Nodes enter on the node channel, one word per node, lowest node of a pass
// first. Results leave on the result channel: the lower boundary on a first
// node, the value at t for the middle of the window when the next node
// arrives, and the upper boundary with pass_end set on a last node.
// Configuration is written through cfg_we, cfg_index and cfg_data. The user
// must write it only while the block is idle; the block does not enforce it.
// A node that completes an interior value runs fifteen products one after
// the other through a single multiplier that handles 16 bits of one operand
// per cycle. Nodes are queued ahead of the solver, so the node channel keeps
// accepting while a result waits; when the receiver stalls, the result
// register holds its word and the queue fills, then node_ready falls.
// Reset empties the queue and the window and restores the register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module explicit_fd_grid_step #(
  parameter int DATA_WIDTH  = 32,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [efd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [efd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 node_valid,
  output logic                                 node_ready,
  input  efd_pkg::node_word_t                  node,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output efd_pkg::result_word_t                result
);

  import efd_pkg::*;

  cfg_t cfg;
  logic job_valid;
  logic job_ready;
  job_t job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_dt    <= STEP_DT_RESET;
      cfg.rate_r     <= RATE_R_RESET;
      cfg.volatility <= VOLATILITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_DT:    cfg.step_dt    <= cfg_data[30:0];
        CFG_RATE_R:     cfg.rate_r     <= cfg_data;
        CFG_VOLATILITY: cfg.volatility <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  efd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .node_valid(node_valid),
    .node_ready(node_ready),
    .node      (node),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  efd_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(job_valid),
    .push_ready(job_ready),
    .push_data (job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_job)
  );

  efd_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pop_valid   (q_valid),
    .pop_ready   (q_ready),
    .pop_data    (q_job),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// File: test/explicit_fd_grid_step_test.sv
// ---------------------------------------------------------------------------
// Grid step testbench
// Streams node words through explicit_fd_grid_step and checks every result
// word against an in-bench Q16.16 model of the sliding window and the update.
// ---------------------------------------------------------------------------
// A short table of directed node words comes first, with boundary results
// and simple interior values written out by hand. Randomized grid passes
// follow under seven register settings, with a few stray words mixed in.
// Both channels idle at random, and one phase runs without the random idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module explicit_fd_grid_step_test;
  import efd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES = 7;
  localparam int PHASE_WORDS = 160;
  localparam int MAX_PRINTED = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct {
    node_word_t   w;
    int           typed;
    result_word_t e0;
    result_word_t e1;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                 node_valid = 1'b0;
  logic                 node_ready;
  node_word_t           node = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_word_t         result;

  // Model of the registers and of the two-node window.
  logic [30:0]        dt_q = STEP_DT_RESET;
  logic signed [31:0] rate_q = RATE_R_RESET;
  logic [30:0]        vol_q = VOLATILITY_RESET;
  logic signed [31:0] win_v_lower = '0;
  logic signed [31:0] win_v_mid = '0;
  logic signed [31:0] win_x_mid = '0;
  logic signed [31:0] win_c [6] = '{default: '0};
  logic [1:0]         win_count = '0;

  result_word_t values_due [$];
  result_word_t fresh [$];
  dir_row_t     dir_rows [$];

  bit no_idle = 1'b0;
  int errors = 0;
  int nodes_sent = 0;
  int results_seen = 0;
  int passes_done = 0;
  int reg_writes = 0;
  int cycles = 0;

  explicit_fd_grid_step u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .node_valid   (node_valid),
    .node_ready   (node_ready),
    .node         (node),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    result_ready <= no_idle || ($urandom_range(99) >= 20);
  end

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p[47:16];
  endfunction

  // Value at t for the middle node, given the upper node's value and weights.
  function automatic logic signed [31:0] solve_node(logic signed [31:0] v_up,
                                                    logic signed [31:0] c1_up,
                                                    logic signed [31:0] c2_up);
    logic signed [31:0] half, dt, sig, d1, d2, t0, t1, t2, sum;
    half = 32'sh0000_8000;
    dt = {1'b0, dt_q};
    sig = {1'b0, vol_q};
    d1 = qmul(win_c[0], win_v_lower) + qmul(win_c[1], win_v_mid) + qmul(c1_up, v_up);
    d2 = qmul(win_c[3], win_v_lower) + qmul(win_c[4], win_v_mid) + qmul(c2_up, v_up);
    t0 = qmul(rate_q, win_v_mid);
    t1 = -qmul(qmul(rate_q, win_x_mid), d1);
    t2 = -qmul(qmul(qmul(half, qmul(sig, sig)), qmul(win_x_mid, win_x_mid)), d2);
    sum = t0 + t1 + t2;
    return win_v_mid - qmul(dt, sum);
  endfunction

  function automatic void advance_window(node_word_t w);
    if (w.first_node) begin
      fresh.push_back({w.boundary_value, 1'b0});
      win_count = 2'd0;
    end
    if (win_count == 2'd2) begin
      fresh.push_back({solve_node(w.v_sample, w.d1_upper, w.d2_upper), 1'b0});
    end
    win_v_lower = win_v_mid;
    win_v_mid = w.v_sample;
    win_x_mid = w.grid_x;
    win_c[0] = w.d1_lower;
    win_c[1] = w.d1_center;
    win_c[2] = w.d1_upper;
    win_c[3] = w.d2_lower;
    win_c[4] = w.d2_center;
    win_c[5] = w.d2_upper;
    if (win_count < 2'd2) begin
      win_count++;
    end
    if (w.last_node) begin
      fresh.push_back({w.boundary_value, 1'b1});
      win_count = 2'd0;
    end
  endfunction

  function automatic node_word_t mk(logic signed [31:0] v, logic signed [31:0] x,
                                    logic signed [31:0] c1l, logic signed [31:0] c1c,
                                    logic signed [31:0] c1u, logic signed [31:0] c2l,
                                    logic signed [31:0] c2c, logic signed [31:0] c2u,
                                    logic signed [31:0] bnd, logic f, logic l);
    node_word_t w;
    w.v_sample = v;
    w.grid_x = x;
    w.d1_lower = c1l;
    w.d1_center = c1c;
    w.d1_upper = c1u;
    w.d2_lower = c2l;
    w.d2_center = c2c;
    w.d2_upper = c2u;
    w.boundary_value = bnd;
    w.first_node = f;
    w.last_node = l;
    return w;
  endfunction

  function automatic logic signed [31:0] rand_word();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic node_word_t rand_node(logic f, logic l);
    return mk(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word(), f, l);
  endfunction

  function automatic void add_row(node_word_t w, int typed, result_word_t e0,
                                  result_word_t e1);
    dir_row_t r;
    r.w = w;
    r.typed = typed;
    r.e0 = e0;
    r.e1 = e1;
    dir_rows.push_back(r);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(node_word_t w, int typed = -1, result_word_t e0 = '0,
                      result_word_t e1 = '0);
    while (!no_idle && $urandom_range(99) < 20) begin
      node_valid <= 1'b0;
      @(negedge clk);
    end
    node <= w;
    node_valid <= 1'b1;
    do @(posedge clk); while (!node_ready);
    nodes_sent++;
    fresh.delete();
    advance_window(w);
    if (typed < 0) begin
      foreach (fresh[i]) values_due.push_back(fresh[i]);
    end else begin
      if (typed >= 1) values_due.push_back(e0);
      if (typed >= 2) values_due.push_back(e1);
    end
    @(negedge clk);
  endtask

  task automatic settle(int tail);
    node_valid <= 1'b0;
    do @(negedge clk); while (values_due.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    reg_writes++;
    case (idx)
      CFG_STEP_DT:    dt_q = data[30:0];
      CFG_RATE_R:     rate_q = data;
      CFG_VOLATILITY: vol_q = data[30:0];
      default: ;
    endcase
  endtask

  task automatic random_pass();
    int n;
    if ($urandom_range(99) < 85) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        send(rand_node(i == 0, i == n - 1));
      end
    end else begin
      send(rand_node($urandom_range(1), $urandom_range(1)));
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (values_due.size() == 0) begin
        report($sformatf("result word with none due: u_value=%h pass_end=%b",
                         result.u_value, result.pass_end));
      end else begin
        want = values_due.pop_front();
        results_seen++;
        if (want.pass_end) passes_done++;
        if (result.u_value !== want.u_value) begin
          report($sformatf("u_value %h, expected %h", result.u_value, want.u_value));
        end
        if (result.pass_end !== want.pass_end) begin
          report($sformatf("pass_end %b, expected %b", result.pass_end, want.pass_end));
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d result words due.", cycles,
             values_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [31:0] set_dt, set_r, set_vol;
    int target;

    // Directed words run under the reset register values, where the rate is
    // zero, so zero weights give an interior value equal to the middle value.
    add_row(mk(5 * ONE, ONE, 0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1'b1, 1'b0), 1,
            {32'h7FFF_FFFF, 1'b0}, '0);
    add_row(mk(-3 * ONE, 2 * ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk(32'sh7FFF_FFFF, 3 * ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0), 1,
            {32'hFFFD_0000, 1'b0}, '0);
    add_row(mk(32'sh8000_0000, 4 * ONE, 0, 0, 0, 0, 0, 0, 32'sh8000_0000, 1'b0, 1'b1), 2,
            {32'h7FFF_FFFF, 1'b0}, {32'h8000_0000, 1'b1});
    add_row(mk(ONE, ONE, 0, 0, 0, 0, 0, 0, 32'sh1234_5678, 1'b1, 1'b1), 2,
            {32'h1234_5678, 1'b0}, {32'h1234_5678, 1'b1});
    add_row(mk(ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0), 1, {32'h0, 1'b0}, '0);
    add_row(mk(2 * ONE, ONE, 0, 0, 0, 0, 0, 0, -1, 1'b0, 1'b1), 1,
            {32'hFFFF_FFFF, 1'b1}, '0);
    add_row(mk(7 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk(-ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0), 0, '0, '0);
    add_row(mk(9 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0), 1,
            {32'hFFFF_0000, 1'b0}, '0);
    add_row(mk(ONE, ONE, 0, 0, 0, 0, 0, 0, 32'sh5A5A_A5A5, 1'b1, 1'b0), 1,
            {32'h5A5A_A5A5, 1'b0}, '0);
    add_row(mk(3 * ONE, 2 * ONE, ONE, -2 * ONE, ONE, ONE, -2 * ONE, ONE, 0, 1'b0, 1'b0),
            -1, '0, '0);
    add_row(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 1'b0, 1'b0), -1, '0, '0);
    add_row(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 1'b0, 1'b0), -1, '0, '0);
    add_row(mk(-ONE, 32'sh0005_8000, -ONE, 0, ONE, ONE, -2 * ONE, ONE, 0, 1'b0, 1'b0),
            -1, '0, '0);
    add_row(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh8000_0000, 1'b0, 1'b1), -1, '0, '0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].e0, dir_rows[i].e1);
    end
    settle(TAIL_CYCLES);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          set_dt = 32'd655;
          set_r = 32'h0000_0CCD;
          set_vol = 32'd13107;
        end
        1: begin
          set_dt = 32'h0;
          set_r = $urandom;
          set_vol = $urandom;
        end
        2: begin
          set_dt = 32'hFFFF_FFFF;
          set_r = 32'h8000_0000;
          set_vol = 32'hFFFF_FFFF;
        end
        3: begin
          set_dt = 32'h7FFF_FFFF;
          set_r = 32'h7FFF_FFFF;
          set_vol = 32'h0;
        end
        5: begin
          set_dt = $urandom_range(1, 32'h0000_4000);
          set_r = -$urandom_range(1, 32'h0001_0000);
          set_vol = 32'h0000_8000;
        end
        default: begin
          set_dt = $urandom;
          set_r = $urandom;
          set_vol = $urandom;
        end
      endcase
      write_reg(CFG_STEP_DT, set_dt);
      write_reg(CFG_RATE_R, set_r);
      write_reg(CFG_VOLATILITY, set_vol);
      if (ph == 4) begin
        write_reg(CFG_SPARE, $urandom);
      end
      cfg_we <= 1'b0;
      @(negedge clk);

      no_idle = (ph == 2);
      target = nodes_sent + PHASE_WORDS / 2;
      while (nodes_sent < target) random_pass();
      // Hold the node channel until the block has delivered everything.
      settle(0);
      target = nodes_sent + PHASE_WORDS / 2;
      while (nodes_sent < target) begin
        if ($urandom_range(39) == 0) settle(0);
        random_pass();
      end
      settle(TAIL_CYCLES);
      no_idle = 1'b0;
    end

    $display("Sent %0d node words and checked %0d result words over %0d ended passes.",
             nodes_sent, results_seen, passes_done);
    $display("Used %0d register settings with %0d register writes; %0d mismatches.",
             PHASES + 1, reg_writes, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/efd_pkg.sv
rtl/core/efd_fifo.sv
rtl/core/efd_mul.sv
rtl/core/efd_front.sv
rtl/core/efd_back.sv
rtl/core/explicit_fd_grid_step.sv
test/explicit_fd_grid_step_test.sv
